// ----- hdl/u8g_pkg.sv -----
// ----------------------------------------------------------------------------
// u8g_pkg
// Types, lead byte codes and the glyph slot map for the utf-8 glyph decoder.
// ----------------------------------------------------------------------------
package u8g_pkg;

    localparam int unsigned CODE_W  = 21;
    localparam int unsigned GLYPH_W = 8;
    localparam int unsigned BYTE_W  = 8;

    typedef logic [CODE_W-1:0]  t_code;
    typedef logic [GLYPH_W-1:0] t_glyph;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [1:0]         t_count;

    // lead byte classes: (byte & mask) == match
    localparam t_byte LEAD2_MASK  = 8'hE0;
    localparam t_byte LEAD2_MATCH = 8'hC0;
    localparam t_byte LEAD3_MASK  = 8'hF0;
    localparam t_byte LEAD3_MATCH = 8'hE0;
    localparam t_byte LEAD4_MASK  = 8'hF8;
    localparam t_byte LEAD4_MATCH = 8'hF0;

    localparam t_count CONT_NONE = 2'd0;
    localparam t_count CONT_ONE  = 2'd1;
    localparam t_count CONT_TWO  = 2'd2;
    localparam t_count CONT_THREE = 2'd3;

    localparam t_code ASCII_FIRST = 21'd32;
    localparam t_code ASCII_LAST  = 21'd127;
    localparam t_code CYR_FIRST   = 21'd1040;
    localparam t_code CYR_LAST    = 21'd1103;
    localparam t_code CYR_OFFSET  = 21'd944;

    // font slot for one code point; unlisted codes take dflt (the last glyph)
    function automatic t_glyph glyph_for(input t_code cp, input t_glyph dflt);
        t_code  diff;
        t_glyph g;
        diff = '0;
        if (cp < ASCII_FIRST) begin
            g = '0;
        end else if (cp <= ASCII_LAST) begin
            diff = cp - ASCII_FIRST;
            g    = diff[GLYPH_W-1:0];
        end else if (cp >= CYR_FIRST && cp <= CYR_LAST) begin
            diff = cp - CYR_OFFSET;
            g    = diff[GLYPH_W-1:0];
        end else begin
            unique case (cp)
                21'd1030: g = 8'd41;
                21'd1031: g = 8'd162;
                21'd1111: g = 8'd163;
                21'd1110: g = 8'd73;
                21'd1028: g = 8'd160;
                21'd1108: g = 8'd161;
                21'd1025: g = 8'd37;
                21'd1105: g = 8'd69;
                21'd1168: g = 8'd164;
                21'd1169: g = 8'd165;
                21'd171,
                21'd187:  g = 8'd2;
                default:  g = dflt;
            endcase
        end
        return g;
    endfunction

endpackage

// ----- hdl/utf8_to_glyph_index_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_to_glyph_index_unit
// Decodes a utf-8 byte stream into code points and font glyph slots.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                      | tlast
//  s       | in  | [7:0] text_byte                         | final_byte
//  m       | out | [20:0] code_point, [28:21] glyph_index  | final_char
//
// one byte is taken every cycle while s tready is high; a result is offered
// from the result register once its completing byte has passed the input register
// lead bytes that open a sequence give no result unless they are the last byte
// reset clears the sequence state and both valid flags
// when the result register is full and not taken, an item held in the input
// register waits there and s tready drops
module utf8_to_glyph_index_unit #(
    parameter int unsigned GLYPH_COUNT = 166
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [20:0] code_point, [28:21] glyph_index
    output logic        o_m_tlast
);

    localparam u8g_pkg::t_glyph LAST_GLYPH = u8g_pkg::GLYPH_W'(GLYPH_COUNT - 1);

    // input register
    logic               r_in_valid;
    u8g_pkg::t_byte     r_in_byte;
    logic               r_in_last;

    // sequence state
    u8g_pkg::t_count    r_bexp, n_bexp;
    u8g_pkg::t_code     r_part, n_part;

    // result register
    logic               r_out_valid;
    u8g_pkg::t_code     r_out_code;
    u8g_pkg::t_glyph    r_out_glyph;
    logic               r_out_last;

    logic               out_free;
    logic               advance;
    logic               emit;
    u8g_pkg::t_code     emit_code;
    logic               emit_last;
    u8g_pkg::t_code     shifted;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    assign shifted = {r_part[u8g_pkg::CODE_W-7:0], r_in_byte[5:0]};

    always_comb begin
        n_bexp    = r_bexp;
        n_part    = r_part;
        emit      = 1'b0;
        emit_code = '0;
        emit_last = r_in_last;
        if (r_bexp != u8g_pkg::CONT_NONE) begin
            n_bexp = r_bexp - 2'd1;
            n_part = shifted;
            if (n_bexp == u8g_pkg::CONT_NONE) begin
                emit      = 1'b1;
                emit_code = shifted;
                n_part    = '0;
            end else if (r_in_last) begin
                // sequence cut short by the last byte
                emit   = 1'b1;
                n_bexp = u8g_pkg::CONT_NONE;
                n_part = '0;
            end
        end else if (!r_in_byte[7]) begin
            emit      = 1'b1;
            emit_code = u8g_pkg::CODE_W'(r_in_byte);
        end else begin
            priority if ((r_in_byte & u8g_pkg::LEAD2_MASK) == u8g_pkg::LEAD2_MATCH) begin
                n_bexp = u8g_pkg::CONT_ONE;
                n_part = u8g_pkg::CODE_W'(r_in_byte[4:0]);
            end else if ((r_in_byte & u8g_pkg::LEAD3_MASK) == u8g_pkg::LEAD3_MATCH) begin
                n_bexp = u8g_pkg::CONT_TWO;
                n_part = u8g_pkg::CODE_W'(r_in_byte[3:0]);
            end else if ((r_in_byte & u8g_pkg::LEAD4_MASK) == u8g_pkg::LEAD4_MATCH) begin
                n_bexp = u8g_pkg::CONT_THREE;
                n_part = u8g_pkg::CODE_W'(r_in_byte[2:0]);
            end else begin
                // stray continuation or invalid lead
                emit = 1'b1;
            end
            if (!emit && r_in_last) begin
                emit   = 1'b1;
                n_bexp = u8g_pkg::CONT_NONE;
                n_part = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_bexp      <= u8g_pkg::CONT_NONE;
            r_part      <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_bexp <= n_bexp;
                r_part <= n_part;
            end
            if (out_free) begin
                r_out_valid <= advance && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (advance && emit) begin
            r_out_code  <= emit_code;
            r_out_glyph <= u8g_pkg::glyph_for(emit_code, LAST_GLYPH);
            r_out_last  <= emit_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_glyph, r_out_code};
    assign o_m_tlast  = r_out_last;

    // no partial code is kept outside an open sequence
    a_part_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bexp == u8g_pkg::CONT_NONE) |-> (r_part == '0))
        else $error("partial code left without open sequence");

    // the last byte of a string always closes any open sequence
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_bexp == u8g_pkg::CONT_NONE))
        else $error("sequence still open after last byte");

    // the last byte of a string always yields a result
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_out_valid && r_out_last))
        else $error("last byte gave no final result");

    // control codes, and the error code zero, map to slot zero
    a_ctrl_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_code < u8g_pkg::ASCII_FIRST) |-> (r_out_glyph == '0))
        else $error("control code with nonzero glyph");

endmodule
